// ===== hw/rtl/swml_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swml_pkg
// Shared widths of the stream words of the sliding window minimum block.
// ----------------------------------------------------------------------------
package swml_pkg;

  // Packed value field and lane count field of one word.
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned CNT_W   = 3;
  // Fields packed from bit 0 and padded to whole bytes.
  localparam int unsigned TDATA_W = ((FIELD_W + CNT_W + 7) / 8) * 8;

endpackage

// ===== hw/rtl/swml_win_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swml_win_cell
// One window entry. On a shift by k entries it loads candidate k, which is
// either a new lane value or the entry k places newer in the chain.
// ----------------------------------------------------------------------------
module swml_win_cell #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned LANES      = 4
) (
  input  logic                              clk,
  input  logic                              shift,
  input  logic [$clog2(LANES + 1) - 1:0]    amount,
  input  logic [VALUE_BITS - 1:0]           cand [1:LANES],
  output logic [VALUE_BITS - 1:0]           value
);

  always_ff @(posedge clk) begin
    if (shift && amount != '0) begin
      value <= cand[amount];
    end
  end

endmodule

// ===== hw/rtl/swml_min_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swml_min_cell
// Registered unsigned minimum of a value and its neighbor in the row below.
// ----------------------------------------------------------------------------
module swml_min_cell #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [VALUE_BITS - 1:0] a,
  input  logic [VALUE_BITS - 1:0] b,
  output logic [VALUE_BITS - 1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= (b < a) ? b : a;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_minimum_lanes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_lanes
// Sliding window minimum over a lane-packed stream, built from a shifting
// chain of window cells and rows of registered minimum cells.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit first)
//  s_*      | in        | packed_smers[63:0], lane_count[66:64], zero pad
//  m_*      | out       | packed_minima[63:0], minima_count[66:64], zero pad
//
// One word is taken per cycle while s_tready is high. A word that yields a
// result passes the row 0 register, then T = floor(log2(WINDOW_SIZE)) rows
// of minimum cells that widen the covered span by doubling, then the m_*
// output register. Words that yield no result leave the pipeline at once.
// rst clears the valid bits and the arrival count, not the window cells. A
// stall on m_tready backs up only as far as the pipeline has no free stage.
// ----------------------------------------------------------------------------
module sliding_window_minimum_lanes #(
  parameter int unsigned WINDOW_SIZE = 8,
  parameter int unsigned VALUE_BITS  = 16,
  parameter int unsigned LANES       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // packed_smers[63:0], lane_count[66:64]
  input  logic [swml_pkg::TDATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // packed_minima[63:0], minima_count[66:64]
  output logic [swml_pkg::TDATA_W-1:0]  m_tdata
);

  import swml_pkg::*;

  localparam int unsigned VB   = VALUE_BITS;
  localparam int unsigned W    = WINDOW_SIZE;
  localparam int unsigned N    = W + LANES - 1;
  localparam int unsigned T    = $clog2(W + 1) - 1;
  localparam int unsigned OFF  = W - (1 << T);
  localparam int unsigned LW   = $clog2(LANES + 1);
  localparam int unsigned AW   = $clog2(W + 1);
  localparam int unsigned SW   = AW + LW;
  localparam int unsigned LIW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned PW   = LANES * VB;

  // Input word fields and lane values.
  logic [FIELD_W-1:0]      in_vals;
  logic [CNT_W-1:0]        in_cnt;
  logic [PW+FIELD_W-1:0]   in_ext;
  logic [VB-1:0]           lane_val [0:LANES-1];
  logic [LW-1:0]           k;
  logic                    in_end;
  logic                    accept;

  // Arrival count and per-word bookkeeping.
  logic [AW-1:0]           arrivals;
  logic [SW-1:0]           arr_sum;
  logic [SW-1:0]           first_lane;
  logic [SW-1:0]           num_min;

  // Window chain, newest entry in cell 0.
  logic [VB-1:0]           win  [0:W-1];
  logic [VB-1:0]           cand [0:W-1][1:LANES];

  // Pipeline rows and sideband.
  logic [VB-1:0]           snap [0:N-1];
  logic [VB-1:0]           lvl  [0:T][0:N-1];
  logic                    vld  [0:T];
  logic                    endf [0:T];
  logic [SW-1:0]           fst  [0:T];
  logic [LW-1:0]           oc   [0:T];
  logic                    take [0:T+1];

  logic [VB-1:0]           mins [0:LANES-1];
  logic [PW+FIELD_W-1:0]   pk;
  logic [SW-1:0]           sel;

  assign in_vals = s_tdata[FIELD_W-1:0];
  assign in_cnt  = s_tdata[FIELD_W +: CNT_W];
  assign in_ext  = (PW + FIELD_W)'(in_vals);
  assign in_end  = (in_cnt == '0);

  always_comb begin
    if (int'(in_cnt) > int'(LANES)) begin
      k = LW'(LANES);
    end else begin
      k = LW'(in_cnt);
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_val[i] = in_ext[i*VB +: VB];
  end

  // Lane i of a word sees a full window once arrivals + i + 1 reaches W.
  always_comb begin
    arr_sum = SW'(arrivals) + SW'(k);
    if (int'(arrivals) >= int'(W) - 1) begin
      first_lane = '0;
    end else begin
      first_lane = SW'(W - 1) - SW'(arrivals);
    end
    if (SW'(k) > first_lane) begin
      num_min = SW'(k) - first_lane;
    end else begin
      num_min = '0;
    end
  end

  // Ready chain: a stage takes a new word when empty or when it moves on.
  assign take[T+1] = !m_tvalid || m_tready;
  for (genvar s = 0; s <= T; s++) begin : g_take
    assign take[s] = !vld[s] || take[s+1];
  end
  assign s_tready = take[0];
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrivals <= '0;
    end else if (accept) begin
      if (in_end) begin
        arrivals <= '0;
      end else if (int'(arr_sum) >= int'(W)) begin
        arrivals <= AW'(W);
      end else begin
        arrivals <= AW'(arr_sum);
      end
    end
  end

  // Window chain. Cell j takes a new lane value when it falls within the
  // shift, otherwise the entry k places newer.
  for (genvar j = 0; j < W; j++) begin : g_win
    for (genvar m = 1; m <= LANES; m++) begin : g_cand
      if (j < m) begin : g_new
        assign cand[j][m] = lane_val[m-1-j];
      end else begin : g_old
        assign cand[j][m] = win[j-m];
      end
    end
    swml_win_cell #(
      .VALUE_BITS (VB),
      .LANES      (LANES)
    ) u_cell (
      .clk    (clk),
      .shift  (accept && !in_end),
      .amount (k),
      .cand   (cand[j]),
      .value  (win[j])
    );
  end

  // Row 0: the W-1 newest old entries, oldest first, then the new lanes.
  // Lane i's window is then the span starting at position i.
  always_ff @(posedge clk) begin
    if (take[0]) begin
      for (int p = 0; p < int'(W) - 1; p++) begin
        snap[p] <= win[int'(W) - 2 - p];
      end
      for (int i = 0; i < int'(LANES); i++) begin
        snap[int'(W) - 1 + i] <= lane_val[i];
      end
      endf[0] <= in_end;
      fst[0]  <= first_lane;
      oc[0]   <= LW'(num_min);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (take[0]) begin
      vld[0] <= s_tvalid && (in_end || num_min != '0);
    end
  end

  for (genvar p = 0; p < N; p++) begin : g_row0
    assign lvl[0][p] = snap[p];
  end

  // Row t holds the minimum of the 2^t entries starting at each position.
  for (genvar t = 1; t <= T; t++) begin : g_row
    localparam int unsigned H = 1 << (t - 1);
    for (genvar p = 0; p < N; p++) begin : g_pos
      swml_min_cell #(
        .VALUE_BITS (VB)
      ) u_min (
        .clk (clk),
        .en  (take[t]),
        .a   (lvl[t-1][p]),
        .b   ((p + H < N) ? lvl[t-1][(p + H < N) ? p + H : p] : lvl[t-1][p]),
        .q   (lvl[t][p])
      );
    end

    always_ff @(posedge clk) begin
      if (take[t]) begin
        endf[t] <= endf[t-1];
        fst[t]  <= fst[t-1];
        oc[t]   <= oc[t-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t] <= 1'b0;
      end else if (take[t]) begin
        vld[t] <= vld[t-1];
      end
    end
  end

  // Two overlapping spans of 2^T entries cover a window of W entries.
  for (genvar i = 0; i < LANES; i++) begin : g_mins
    assign mins[i] = (lvl[T][i + OFF] < lvl[T][i]) ? lvl[T][i + OFF] : lvl[T][i];
  end

  // Pack the minima of the emitting lanes densely from lane 0.
  always_comb begin
    pk  = '0;
    sel = '0;
    if (!endf[T]) begin
      for (int o = 0; o < int'(LANES); o++) begin
        sel = fst[T] + SW'(o);
        if (o < int'(oc[T]) && int'(sel) < int'(LANES)) begin
          pk[o*VB +: VB] = mins[sel[LIW-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take[T+1]) begin
      m_tvalid <= vld[T];
    end
  end

  always_ff @(posedge clk) begin
    if (take[T+1]) begin
      m_tdata <= TDATA_W'({(endf[T] ? CNT_W'(0) : CNT_W'(oc[T])), pk[FIELD_W-1:0]});
    end
  end

endmodule
